@@ sv/cltok_pkg.sv @@
package cltok_pkg;

  localparam logic [7:0] CH_BLANK  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // result queue geometry
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ARG    = 2'd1,
    MODE_QUOTED = 2'd2
  } mode_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       last;
  } result_t;

  // what one item hands to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } step_out_t;

endpackage

@@ sv/cltok_step.sv @@
module cltok_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            char_in,
  input  logic                  line_end,
  output cltok_pkg::step_out_t  step
);

  cltok_pkg::mode_t mode, mode_next;
  logic             esc, esc_next;

  cltok_pkg::mode_t mode_eff;
  cltok_pkg::mode_t plain_mode;
  logic             plain_emit;
  logic             plain_kind;
  logic [7:0]       plain_ch;
  logic             plain_esc;
  logic             a_v, b_v;
  logic [7:0]       a_ch;
  logic             b_kind;
  logic [7:0]       b_ch;
  logic             hit;
  logic [7:0]       mapped;

  // unused encoding behaves as inside an argument
  always_comb begin
    unique case (mode)
      cltok_pkg::MODE_IDLE:   mode_eff = cltok_pkg::MODE_IDLE;
      cltok_pkg::MODE_QUOTED: mode_eff = cltok_pkg::MODE_QUOTED;
      default:                mode_eff = cltok_pkg::MODE_ARG;
    endcase
  end

  always_comb begin
    hit    = 1'b1;
    mapped = char_in;
    unique case (char_in)
      cltok_pkg::CH_QUOTE:  mapped = cltok_pkg::CH_QUOTE;
      cltok_pkg::CH_N:      mapped = cltok_pkg::CH_LF;
      cltok_pkg::CH_R:      mapped = cltok_pkg::CH_CR;
      cltok_pkg::CH_T:      mapped = cltok_pkg::CH_TAB;
      cltok_pkg::CH_BSLASH: mapped = cltok_pkg::CH_BSLASH;
      default:              hit    = 1'b0;
    endcase
  end

  // ordinary handling of one character
  always_comb begin
    plain_mode = mode_eff;
    plain_emit = 1'b0;
    plain_kind = cltok_pkg::KIND_CHAR;
    plain_ch   = char_in;
    plain_esc  = 1'b0;
    priority if (char_in == cltok_pkg::CH_BLANK) begin
      if (mode_eff == cltok_pkg::MODE_QUOTED) begin
        plain_emit = 1'b1;
      end else if (mode_eff != cltok_pkg::MODE_IDLE) begin
        plain_emit = 1'b1;
        plain_kind = cltok_pkg::KIND_END;
        plain_ch   = 8'd0;
        plain_mode = cltok_pkg::MODE_IDLE;
      end
    end else if (char_in == cltok_pkg::CH_QUOTE) begin
      plain_mode = (mode_eff == cltok_pkg::MODE_QUOTED) ? cltok_pkg::MODE_ARG
                                                        : cltok_pkg::MODE_QUOTED;
    end else if (char_in == cltok_pkg::CH_BSLASH) begin
      plain_esc = 1'b1;
      if (mode_eff == cltok_pkg::MODE_IDLE) plain_mode = cltok_pkg::MODE_ARG;
    end else begin
      plain_emit = 1'b1;
      if (mode_eff == cltok_pkg::MODE_IDLE) plain_mode = cltok_pkg::MODE_ARG;
    end
  end

  // slot a: escape output, slot b: what follows it
  always_comb begin
    mode_next = mode_eff;
    esc_next  = esc;
    a_v       = 1'b0;
    a_ch      = cltok_pkg::CH_BSLASH;
    b_v       = 1'b0;
    b_kind    = cltok_pkg::KIND_CHAR;
    b_ch      = 8'd0;
    priority if (line_end) begin
      a_v       = esc;
      b_v       = (mode_eff != cltok_pkg::MODE_IDLE);
      b_kind    = cltok_pkg::KIND_END;
      mode_next = cltok_pkg::MODE_IDLE;
      esc_next  = 1'b0;
    end else if (esc && hit) begin
      a_v      = 1'b1;
      a_ch     = mapped;
      esc_next = 1'b0;
    end else begin
      a_v       = esc;
      b_v       = plain_emit;
      b_kind    = plain_kind;
      b_ch      = plain_ch;
      mode_next = plain_mode;
      esc_next  = plain_esc;
    end
  end

  always_comb begin
    step.cnt     = {a_v & b_v, a_v ^ b_v};
    step.r1.kind = b_kind;
    step.r1.ch   = b_ch;
    step.r1.last = 1'b1;
    if (a_v) begin
      step.r0.kind = cltok_pkg::KIND_CHAR;
      step.r0.ch   = a_ch;
      step.r0.last = !b_v;
    end else begin
      step.r0 = step.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cltok_pkg::MODE_IDLE;
      esc  <= 1'b0;
    end else if (advance) begin
      mode <= mode_next;
      esc  <= esc_next;
    end
  end

  // a pending backslash always sits inside an argument
  a_esc_in_arg: assert property (@(posedge clk) disable iff (rst)
    !(esc && mode == cltok_pkg::MODE_IDLE))
    else $error("escape pending between arguments");

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    mode != 2'd3)
    else $error("illegal mode encoding");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    advance && line_end |=> mode == cltok_pkg::MODE_IDLE && !esc)
    else $error("line end did not return to idle");

endmodule

@@ sv/cltok_outq.sv @@
module cltok_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  cltok_pkg::step_out_t push,
  input  logic                 pop,
  output logic                 room,
  output logic                 not_empty,
  output cltok_pkg::result_t   head
);

  cltok_pkg::result_t mem [cltok_pkg::OQ_DEPTH];

  logic [cltok_pkg::OQ_AW-1:0] wp, rp;
  logic [cltok_pkg::OQ_CW-1:0] count;
  logic [cltok_pkg::OQ_AW-1:0] wp1;

  assign wp1       = wp + {{(cltok_pkg::OQ_AW-1){1'b0}}, 1'b1};
  assign not_empty = (count != '0);
  // two free entries, ignoring this cycle's pop to keep ready off the out side
  assign room      = (count <= cltok_pkg::OQ_CW'(cltok_pkg::OQ_DEPTH - 2));
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wp] <= push.r0;
    if (push.cnt == 2'd2) mem[wp1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push.cnt[cltok_pkg::OQ_AW-1:0];
      rp    <= rp + {{(cltok_pkg::OQ_AW-1){1'b0}}, pop};
      count <= count + {{(cltok_pkg::OQ_CW-2){1'b0}}, push.cnt}
                     - {{(cltok_pkg::OQ_CW-1){1'b0}}, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= cltok_pkg::OQ_CW'(cltok_pkg::OQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> room)
    else $error("push without room");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty result queue");

endmodule

@@ sv/command_line_tokenizer_core.sv @@
// Splits a command line, fed one character per beat and closed by a line_end beat, into
// arguments at unquoted blanks, strips double quotes and decodes backslash escapes. Each
// argument comes out as its characters (kind 0) followed by an end marker (kind 1); last
// marks the final result of each input beat, and a beat may give none, one or two results.
// The first result of a beat is valid once the beat has passed the input register and the
// result queue. One input beat is taken per cycle while each gives at most one result and
// out_ready stays high; two results of a beat share the single output port, which the
// four-entry result queue absorbs, stalling input when it runs short of two free entries.
module command_line_tokenizer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] char_out,
  output logic       last
);

  logic       a_valid;
  logic [7:0] a_char;
  logic       a_eol;
  logic       advance;
  logic       room;
  logic       not_empty;

  cltok_pkg::step_out_t step, push;
  cltok_pkg::result_t   head;

  assign advance  = a_valid && room;
  assign in_ready = !a_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_char <= char_in;
      a_eol  <= line_end;
    end
  end

  cltok_step u_step (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .char_in  (a_char),
    .line_end (a_eol),
    .step     (step)
  );

  always_comb begin
    push = step;
    if (!advance) push.cnt = 2'd0;
  end

  cltok_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (out_valid && out_ready),
    .room      (room),
    .not_empty (not_empty),
    .head      (head)
  );

  assign out_valid = not_empty;
  assign kind      = head.kind;
  assign char_out  = head.ch;
  assign last      = head.last;

endmodule

@@ verif/command_line_tokenizer_core_tb.sv @@
`timescale 1ns / 100ps

module command_line_tokenizer_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 90;
  localparam int MAX_PRINTS  = 40;

  class arg_scoreboard;
    cltok_pkg::mode_t   tok_mode;
    bit                 bs_held;
    cltok_pkg::result_t beat_res[$];
    cltok_pkg::result_t expected_q[$];
    int                 errors;

    function new();
      tok_mode = cltok_pkg::MODE_IDLE;
      bs_held  = 1'b0;
      errors   = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endtask

    // the block emits at most two results per beat
    function void emit(logic k, logic [7:0] ch);
      cltok_pkg::result_t r;
      if (beat_res.size() >= 2) return;
      r.kind = k;
      r.ch   = (k == cltok_pkg::KIND_END) ? 8'h00 : ch;
      r.last = 1'b0;
      beat_res.push_back(r);
    endfunction

    function void plain_char(logic [7:0] c);
      if (c == cltok_pkg::CH_BLANK) begin
        if (tok_mode == cltok_pkg::MODE_QUOTED) begin
          emit(cltok_pkg::KIND_CHAR, c);
        end else if (tok_mode != cltok_pkg::MODE_IDLE) begin
          emit(cltok_pkg::KIND_END, 8'h00);
          tok_mode = cltok_pkg::MODE_IDLE;
        end
      end else if (c == cltok_pkg::CH_QUOTE) begin
        tok_mode = (tok_mode == cltok_pkg::MODE_QUOTED) ? cltok_pkg::MODE_ARG
                                                        : cltok_pkg::MODE_QUOTED;
      end else if (c == cltok_pkg::CH_BSLASH) begin
        bs_held = 1'b1;
        if (tok_mode == cltok_pkg::MODE_IDLE) tok_mode = cltok_pkg::MODE_ARG;
      end else begin
        emit(cltok_pkg::KIND_CHAR, c);
        if (tok_mode == cltok_pkg::MODE_IDLE) tok_mode = cltok_pkg::MODE_ARG;
      end
    endfunction

    function void note_beat(logic [7:0] c, logic eol);
      logic [7:0] mapped;
      bit         hit;
      beat_res.delete();
      if (eol) begin
        if (bs_held) begin
          emit(cltok_pkg::KIND_CHAR, cltok_pkg::CH_BSLASH);
          bs_held = 1'b0;
        end
        if (tok_mode != cltok_pkg::MODE_IDLE) emit(cltok_pkg::KIND_END, 8'h00);
        tok_mode = cltok_pkg::MODE_IDLE;
      end else if (bs_held) begin
        bs_held = 1'b0;
        hit     = 1'b1;
        mapped  = cltok_pkg::CH_BSLASH;
        case (c)
          cltok_pkg::CH_QUOTE:  mapped = cltok_pkg::CH_QUOTE;
          cltok_pkg::CH_N:      mapped = cltok_pkg::CH_LF;
          cltok_pkg::CH_R:      mapped = cltok_pkg::CH_CR;
          cltok_pkg::CH_T:      mapped = cltok_pkg::CH_TAB;
          cltok_pkg::CH_BSLASH: mapped = cltok_pkg::CH_BSLASH;
          default:              hit = 1'b0;
        endcase
        if (hit) begin
          emit(cltok_pkg::KIND_CHAR, mapped);
        end else begin
          // unknown escape: backslash goes out, the char is taken as usual
          emit(cltok_pkg::KIND_CHAR, cltok_pkg::CH_BSLASH);
          plain_char(c);
        end
      end else begin
        plain_char(c);
      end
      if (beat_res.size() > 0) beat_res[beat_res.size() - 1].last = 1'b1;
      foreach (beat_res[i]) expected_q.push_back(beat_res[i]);
    endfunction

    task check_result(logic k, logic [7:0] ch, logic lst);
      cltok_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind=%0b char=%02h last=%0b", k, ch, lst));
        return;
      end
      want = expected_q.pop_front();
      if (k !== want.kind) begin
        report($sformatf("kind got %0b want %0b", k, want.kind));
      end
      if (ch !== want.ch) begin
        report($sformatf("char_out got %02h want %02h", ch, want.ch));
      end
      if (lst !== want.last) begin
        report($sformatf("last got %0b want %0b", lst, want.last));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_in;
  logic       line_end;
  logic       out_valid;
  logic       out_ready;
  logic       kind;
  logic [7:0] char_out;
  logic       last;

  arg_scoreboard sb;
  int            items_sent;
  int            tx_idle_pct;
  int            rx_idle_pct;
  bit            hold_off_req;
  int            cycle_cnt = 0;

  command_line_tokenizer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_in   (char_in),
    .line_end  (line_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .char_out  (char_out),
    .last      (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL command_line_tokenizer_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_beat(char_in, line_end);
      if (out_valid && out_ready) sb.check_result(kind, char_out, last);
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic [7:0] c, input logic e);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= c;
    line_end <= e;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.expected_q.size() != 0);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(8'h21, 8'h7e));
    if (r < 55) return cltok_pkg::CH_BLANK;
    if (r < 65) return cltok_pkg::CH_QUOTE;
    if (r < 78) return cltok_pkg::CH_BSLASH;
    if (r < 88) begin
      case ($urandom_range(0, 2))
        0:       return cltok_pkg::CH_N;
        1:       return cltok_pkg::CH_R;
        default: return cltok_pkg::CH_T;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed lines with random content, some raw noise
  task automatic run_lines(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          send_beat(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
        end
      end else begin
        repeat ($urandom_range(0, 20)) send_beat(pick_char(), 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    char_in      = 8'h00;
    line_end     = 1'b0;
    out_ready    = 1'b0;
    items_sent   = 0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 20;
    hold_off_req = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero byte starts an argument, blank closes it
    send_beat(8'h00, 1'b0);
    send_beat(cltok_pkg::CH_BLANK, 1'b0);
    // empty quoted argument, then an empty line
    send_beat(cltok_pkg::CH_QUOTE, 1'b0);
    send_beat(cltok_pkg::CH_QUOTE, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'hff, 1'b1);
    // all-blank line
    send_beat(cltok_pkg::CH_BLANK, 1'b0);
    send_beat(8'h00, 1'b1);
    // every escape, an unknown one and an escaped blank
    send_beat(cltok_pkg::CH_BSLASH, 1'b0);
    send_beat(cltok_pkg::CH_N, 1'b0);
    send_beat(cltok_pkg::CH_BSLASH, 1'b0);
    send_beat(cltok_pkg::CH_R, 1'b0);
    send_beat(cltok_pkg::CH_BSLASH, 1'b0);
    send_beat(cltok_pkg::CH_T, 1'b0);
    send_beat(cltok_pkg::CH_BSLASH, 1'b0);
    send_beat(cltok_pkg::CH_QUOTE, 1'b0);
    send_beat(cltok_pkg::CH_BSLASH, 1'b0);
    send_beat(cltok_pkg::CH_BSLASH, 1'b0);
    send_beat(cltok_pkg::CH_BSLASH, 1'b0);
    send_beat(8'h71, 1'b0);
    send_beat(cltok_pkg::CH_BSLASH, 1'b0);
    send_beat(cltok_pkg::CH_BLANK, 1'b0);
    // unterminated quote holding a blank
    send_beat(cltok_pkg::CH_QUOTE, 1'b0);
    send_beat(cltok_pkg::CH_BLANK, 1'b0);
    send_beat(8'h00, 1'b1);
    // dangling backslash at end of line
    send_beat(cltok_pkg::CH_BSLASH, 1'b0);
    send_beat(8'hff, 1'b1);
    wait_drain();

    tx_idle_pct = 15;
    rx_idle_pct = 15;
    run_lines(700);

    // long receiver hold-off while beats keep coming, then drain fully
    tx_idle_pct  = 0;
    hold_off_req = 1'b1;
    run_lines(40);
    wait_drain();

    tx_idle_pct = 0;
    rx_idle_pct = 30;
    run_lines(450);

    tx_idle_pct = 25;
    rx_idle_pct = 0;
    run_lines(350);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_lines(400);

    wait_drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS command_line_tokenizer_core");
    end else begin
      $display("FAIL command_line_tokenizer_core");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/cltok_pkg.sv
sv/cltok_step.sv
sv/cltok_outq.sv
sv/command_line_tokenizer_core.sv
verif/command_line_tokenizer_core_tb.sv
